/* sv/tsrr_pkg.sv */
// ----------------------------------------------------------------------------
// tsrr_pkg
// Shared constants and codes for the round-robin thread slot scheduler.
// ----------------------------------------------------------------------------
package tsrr_pkg;

  // Table size and derived widths
  localparam int MAX_THREADS = 64;
  localparam int IDX_W       = $clog2(MAX_THREADS);
  localparam int CNT_W       = $clog2(MAX_THREADS + 1);

  // Request codes
  localparam logic [1:0] REQ_CREATE = 2'd0;
  localparam logic [1:0] REQ_YIELD  = 2'd1;
  localparam logic [1:0] REQ_EXIT   = 2'd2;
  localparam logic [1:0] REQ_QUERY  = 2'd3;

  // Slot status codes
  localparam logic [1:0] ST_UNUSED = 2'd0;
  localparam logic [1:0] ST_WAIT   = 2'd1;
  localparam logic [1:0] ST_RUN    = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  // Result codes
  localparam logic [1:0] RC_OK     = 2'd0;
  localparam logic [1:0] RC_FULL   = 2'd1;
  localparam logic [1:0] RC_NOWAIT = 2'd2;
  localparam logic [1:0] RC_HALT   = 2'd3;

  typedef logic [IDX_W-1:0] slot_idx_t;
  typedef logic [CNT_W-1:0] slot_cnt_t;

  // Advance a slot index with wrap at the table bound
  function automatic slot_idx_t next_idx(input slot_idx_t i);
    slot_idx_t r;
    if (i == slot_idx_t'(MAX_THREADS - 1)) begin
      r = '0;
    end else begin
      r = i + 1'b1;
    end
    return r;
  endfunction

endpackage

/* sv/thread_slot_round_robin_scheduler_unit.sv */
// ----------------------------------------------------------------------------
// thread_slot_round_robin_scheduler_unit
// Thread slot table with create, round-robin yield, exit and status query.
// ----------------------------------------------------------------------------
// Full, halt and single-thread cases go straight to the result beat. A query
// reads its slot first; a create checks the running slot, then writes the new
// one; a yield or exit scans, reading one slot of the table memory per cycle.
// Throughput: one request at a time; the next beat is taken once the result
// beat has been taken. Reset: slot 0 running, all others unused, no scan pass.
module thread_slot_round_robin_scheduler_unit
  import tsrr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_req_type,
  input  logic [5:0] in_thread_id,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] out_running_thread,
  output logic [5:0] out_new_thread_id,
  output logic [1:0] out_slot_status,
  output logic [1:0] out_result_code
);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_QRY    = 3'd1;
  localparam logic [2:0] S_RUNCHK = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_WRHIT  = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0] st_r, st_nxt;
  logic [1:0] op_r, op_nxt;
  slot_cnt_t  nfs_r, nfs_nxt;
  slot_cnt_t  live_r, live_nxt;
  slot_idx_t  running_r, running_nxt;
  slot_idx_t  scan_r, scan_nxt;
  slot_idx_t  hit_r, hit_nxt;
  slot_cnt_t  chk_r, chk_nxt;
  logic       runrun_r, runrun_nxt;
  logic       s0w_r, s0w_nxt;
  logic [5:0] new_id_r, new_id_nxt;
  logic [1:0] status_r, status_nxt;
  logic [1:0] code_r, code_nxt;

  // Slot table memory
  logic [1:0] mem [MAX_THREADS];
  logic       mem_we;
  slot_idx_t  mem_waddr;
  logic [1:0] mem_wdata;
  slot_idx_t  mem_raddr;
  logic [1:0] rd_data_r;
  slot_idx_t  rd_idx_r;
  logic [1:0] rd_st;

  // Resolve never-written entries: beyond the fill count is unused,
  // slot 0 before its first write is running
  always_comb begin
    if (slot_cnt_t'(rd_idx_r) >= nfs_r) begin
      rd_st = ST_UNUSED;
    end else if (rd_idx_r == '0 && !s0w_r) begin
      rd_st = ST_RUN;
    end else begin
      rd_st = rd_data_r;
    end
  end

  // Sequencer next state and memory control
  always_comb begin
    st_nxt      = st_r;
    op_nxt      = op_r;
    nfs_nxt     = nfs_r;
    live_nxt    = live_r;
    running_nxt = running_r;
    hit_nxt     = hit_r;
    chk_nxt     = chk_r;
    runrun_nxt  = runrun_r;
    new_id_nxt  = new_id_r;
    status_nxt  = status_r;
    code_nxt    = code_r;
    mem_we      = 1'b0;
    mem_waddr   = running_r;
    mem_wdata   = ST_UNUSED;
    mem_raddr   = next_idx(scan_r);

    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_req_type;
          new_id_nxt = '0;
          status_nxt = ST_UNUSED;
          code_nxt   = RC_OK;
          unique case (in_req_type)
            REQ_CREATE: begin
              if (nfs_r == slot_cnt_t'(MAX_THREADS)) begin
                code_nxt = RC_FULL;
                st_nxt   = S_OUT;
              end else begin
                mem_raddr = running_r;
                st_nxt    = S_RUNCHK;
              end
            end
            REQ_YIELD: begin
              if (live_r == slot_cnt_t'(1)) begin
                st_nxt = S_OUT;
              end else begin
                mem_raddr = running_r;
                st_nxt    = S_RUNCHK;
              end
            end
            REQ_EXIT: begin
              if (running_r == '0) begin
                code_nxt = RC_HALT;
                st_nxt   = S_OUT;
              end else begin
                mem_raddr = running_r;
                st_nxt    = S_RUNCHK;
              end
            end
            REQ_QUERY: begin
              if (int'(in_thread_id) >= MAX_THREADS) begin
                st_nxt = S_OUT;
              end else begin
                mem_raddr = slot_idx_t'(in_thread_id);
                st_nxt    = S_QRY;
              end
            end
            default: st_nxt = S_OUT;
          endcase
        end
      end

      S_QRY: begin
        status_nxt = rd_st;
        st_nxt     = S_OUT;
      end

      // Running slot status is in; park the creator, retire the exiter or start the yield scan
      S_RUNCHK: begin
        unique case (op_r)
          REQ_CREATE: begin
            if (rd_st == ST_RUN) begin
              mem_we    = 1'b1;
              mem_wdata = ST_WAIT;
            end
            hit_nxt    = slot_idx_t'(nfs_r);
            new_id_nxt = 6'(nfs_r);
            nfs_nxt    = nfs_r + 1'b1;
            live_nxt   = live_r + 1'b1;
            st_nxt     = S_WRHIT;
          end
          REQ_YIELD: begin
            runrun_nxt = (rd_st == ST_RUN);
            mem_raddr  = next_idx(running_r);
            chk_nxt    = slot_cnt_t'(MAX_THREADS - 1);
            st_nxt     = S_SCAN;
          end
          REQ_EXIT: begin
            if (rd_st == ST_RUN) begin
              mem_we    = 1'b1;
              mem_wdata = ST_DONE;
              if (live_r != '0) begin
                live_nxt = live_r - 1'b1;
              end
            end
            mem_raddr = '0;
            chk_nxt   = slot_cnt_t'(MAX_THREADS);
            st_nxt    = S_SCAN;
          end
          default: st_nxt = S_OUT;
        endcase
      end

      // Check one slot per cycle while the next read is in flight
      S_SCAN: begin
        chk_nxt = chk_r - 1'b1;
        if (rd_st == ST_WAIT) begin
          hit_nxt = rd_idx_r;
          if (op_r == REQ_YIELD && runrun_r) begin
            mem_we    = 1'b1;
            mem_wdata = ST_WAIT;
          end
          st_nxt = S_WRHIT;
        end else if (chk_r == slot_cnt_t'(1)) begin
          if (op_r == REQ_EXIT) begin
            code_nxt = RC_NOWAIT;
          end
          st_nxt = S_OUT;
        end
      end

      // Mark the chosen slot running
      S_WRHIT: begin
        mem_we      = 1'b1;
        mem_waddr   = hit_r;
        mem_wdata   = ST_RUN;
        running_nxt = hit_r;
        st_nxt      = S_OUT;
      end

      // Hold the result beat until taken
      S_OUT: begin
        if (out_ready) begin
          st_nxt = S_IDLE;
        end
      end

      default: st_nxt = S_IDLE;
    endcase

    scan_nxt = mem_raddr;
    s0w_nxt  = s0w_r | (mem_we && mem_waddr == '0);
  end

  // Table memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
    rd_idx_r  <= mem_raddr;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      nfs_r     <= slot_cnt_t'(1);
      live_r    <= slot_cnt_t'(1);
      running_r <= '0;
      s0w_r     <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      nfs_r     <= nfs_nxt;
      live_r    <= live_nxt;
      running_r <= running_nxt;
      s0w_r     <= s0w_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    scan_r   <= scan_nxt;
    hit_r    <= hit_nxt;
    chk_r    <= chk_nxt;
    runrun_r <= runrun_nxt;
    new_id_r <= new_id_nxt;
    status_r <= status_nxt;
    code_r   <= code_nxt;
  end

  assign in_ready           = (st_r == S_IDLE);
  assign out_valid          = (st_r == S_OUT);
  assign out_running_thread = 6'(running_r);
  assign out_new_thread_id  = new_id_r;
  assign out_slot_status    = status_r;
  assign out_result_code    = code_r;

  // Checks
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready and result valid together");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nfs_r <= slot_cnt_t'(MAX_THREADS)) else $error("fill count beyond table");

  a_running_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    slot_cnt_t'(running_r) < nfs_r) else $error("running slot never allocated");

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= nfs_r) else $error("live count above allocated slots");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(running_r))
    else $error("result changed while stalled");

endmodule
